[design/arhe_pkg.sv]
// Package for the attack/release hysteresis envelope smoother.
// Holds field widths, register map codes, item and configuration types.
// No dependencies.
package arhe_pkg;

  // Field widths
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 16;

  // Default channel count
  localparam int unsigned CHANNELS_DEF = 8;

  // Q1.15 unity
  localparam logic [COEF_W-1:0] ONE_Q15 = 16'd32768;

  // Fraction bits of the coefficients: the final shift is by 15
  localparam int unsigned FRAC_BITS = 15;

  // Saturation limits of the sample range
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // APB port geometry
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register map, word index into the register list
  typedef enum logic [1:0] {
    REG_ATTACK_FACTOR  = 2'd0,
    REG_RELEASE_FACTOR = 2'd1,
    REG_ATTACK_RATIO   = 2'd2,
    REG_RELEASE_RATIO  = 2'd3
  } reg_idx_e;

  // Configuration bundle from the register file to the datapath
  typedef struct packed {
    logic [COEF_W-1:0] attack_factor;
    logic [COEF_W-1:0] release_factor;
    logic [COEF_W-1:0] attack_threshold_ratio;
    logic [COEF_W-1:0] release_threshold_ratio;
  } cfg_t;

  // Input transaction payload
  typedef struct packed {
    logic [CHAN_W-1:0]          channel_index;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [CHAN_W-1:0]          channel_out;
    logic signed [SAMPLE_W-1:0] envelope_out;
  } out_item_t;

endpackage

[design/arhe_if.sv]
// Valid/ready stream interfaces for the envelope smoother.
// Depends on arhe_pkg for the payload types.

// Sample stream: channel number and sample
interface arhe_in_if;
  logic               valid;
  logic               ready;
  arhe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result stream: channel number and smoothed value
interface arhe_out_if;
  logic                valid;
  logic                ready;
  arhe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/arhe_cfg_regs.sv]
// APB register file for the envelope smoother: blend factors and hysteresis ratios.
// Depends on arhe_pkg for the register map and the configuration bundle.
module arhe_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arhe_pkg::PADDR_W-1:0]  paddr,
  input  logic [arhe_pkg::PDATA_W-1:0]  pwdata,
  output logic [arhe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output arhe_pkg::cfg_t                cfg_o
);

  arhe_pkg::cfg_t     cfg_q;
  arhe_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = arhe_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_factor           <= '0;
      cfg_q.release_factor          <= '0;
      cfg_q.attack_threshold_ratio  <= arhe_pkg::ONE_Q15;
      cfg_q.release_threshold_ratio <= arhe_pkg::ONE_Q15;
    end else if (wr_en) begin
      case (reg_idx)
        arhe_pkg::REG_ATTACK_FACTOR:  cfg_q.attack_factor <= pwdata[arhe_pkg::COEF_W-1:0];
        arhe_pkg::REG_RELEASE_FACTOR: cfg_q.release_factor <= pwdata[arhe_pkg::COEF_W-1:0];
        arhe_pkg::REG_ATTACK_RATIO: begin
          cfg_q.attack_threshold_ratio <= pwdata[arhe_pkg::COEF_W-1:0];
        end
        arhe_pkg::REG_RELEASE_RATIO: begin
          cfg_q.release_threshold_ratio <= pwdata[arhe_pkg::COEF_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      arhe_pkg::REG_ATTACK_FACTOR:  prdata = arhe_pkg::PDATA_W'(cfg_q.attack_factor);
      arhe_pkg::REG_RELEASE_FACTOR: prdata = arhe_pkg::PDATA_W'(cfg_q.release_factor);
      arhe_pkg::REG_ATTACK_RATIO:   prdata = arhe_pkg::PDATA_W'(cfg_q.attack_threshold_ratio);
      arhe_pkg::REG_RELEASE_RATIO:  prdata = arhe_pkg::PDATA_W'(cfg_q.release_threshold_ratio);
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/attack_release_hysteresis_envelope.sv]
// Top level of the attack/release envelope smoother with hysteresis.
// Depends on arhe_pkg, arhe_if (stream interfaces) and arhe_cfg_regs.
//
// One sample enters and one smoothed value leaves per clock while out_o.ready
// holds; a sample passes the sample register, then the result register. The
// per-channel state lives in a small memory read when a sample is accepted;
// the value written by the item just ahead is forwarded, so samples of the
// same channel may follow each other directly. A channel number at or above
// CHANNELS leaves all state alone and yields zero. Between the sample and the
// result register sit two hysteresis and two blend multiplies in parallel,
// then selection, rounding and saturation; this path sets the clock rate.
// The user must write configuration registers over APB only while the block
// is idle (not enforced by the block); after reset every channel reads zero.
module attack_release_hysteresis_envelope #(
  parameter int unsigned CHANNELS = arhe_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  arhe_in_if.sink                      in_i,
  arhe_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arhe_pkg::PADDR_W-1:0] paddr,
  input  logic [arhe_pkg::PDATA_W-1:0] pwdata,
  output logic [arhe_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned SW    = arhe_pkg::SAMPLE_W;
  localparam int unsigned CW    = arhe_pkg::COEF_W;
  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W = SW + CW + 1;   // prev * ratio, signed
  localparam int unsigned ACC_W = SW + CW + 3;   // blend accumulator
  localparam int unsigned RND_W = ACC_W - arhe_pkg::FRAC_BITS;

  arhe_pkg::cfg_t cfg;

  arhe_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake and pipeline control
  logic in_acc;
  logic s1_go;
  logic s1_valid_q;
  logic out_valid_q;

  // Sample stage
  logic [arhe_pkg::CHAN_W-1:0] s1_chan_q;
  logic signed [SW-1:0]        s1_sample_q;
  logic                        s1_in_range_q;
  logic signed [SW-1:0]        s1_rdata_q;
  logic                        s1_written_q;
  logic                        s1_fwd_q;
  logic signed [SW-1:0]        s1_fwd_data_q;

  // State store
  logic signed [SW-1:0] state_mem [CHANNELS];
  logic [CHANNELS-1:0]  written_q;
  logic [AW-1:0]        rd_addr;
  logic                 rd_in_range;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;

  // Datapath
  logic signed [SW-1:0]    prev;
  logic signed [CMP_W-1:0] prev_att;
  logic signed [CMP_W-1:0] prev_rel;
  logic signed [CMP_W-1:0] sample_sc;
  logic signed [SW:0]      diff;
  logic signed [ACC_W-1:0] acc_att;
  logic signed [ACC_W-1:0] acc_rel;
  logic signed [ACC_W-1:0] acc_sel;
  logic signed [RND_W-1:0] rounded;
  logic signed [SW-1:0]    blended;
  logic                    attack_hit;
  logic                    release_hit;
  logic signed [SW-1:0]    next_value;

  arhe_pkg::out_item_t out_q;

  // Advance the sample stage when the result register is free or drains
  assign s1_go      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_acc     = in_i.valid && in_i.ready;

  assign rd_addr     = AW'(in_i.data.channel_index);
  assign rd_in_range = 32'(in_i.data.channel_index) < CHANNELS;
  assign wr_addr     = AW'(s1_chan_q);
  assign wr_en       = s1_go && s1_in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the sample, the stored value and the forwarding decision
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_chan_q     <= in_i.data.channel_index;
      s1_sample_q   <= in_i.data.sample_in;
      s1_in_range_q <= rd_in_range;
      s1_rdata_q    <= state_mem[rd_addr];
      s1_written_q  <= rd_in_range && written_q[rd_addr];
      s1_fwd_q      <= wr_en && (wr_addr == rd_addr);
      s1_fwd_data_q <= next_value;
    end
  end

  // Store the new value of the channel
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      state_mem[wr_addr] <= next_value;
    end
  end

  // Mark channels that hold a stored value; the rest read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  // Pick the previous value: forwarded, stored or reset
  always_comb begin
    if (s1_fwd_q) begin
      prev = s1_fwd_data_q;
    end else if (s1_written_q) begin
      prev = s1_rdata_q;
    end else begin
      prev = '0;
    end
  end

  // Hysteresis tests: prev * ratio against sample * one
  assign prev_att  = CMP_W'(prev) * $signed({1'b0, cfg.attack_threshold_ratio});
  assign prev_rel  = CMP_W'(prev) * $signed({1'b0, cfg.release_threshold_ratio});
  assign sample_sc = CMP_W'(s1_sample_q) <<< arhe_pkg::FRAC_BITS;
  assign attack_hit  = prev_att < sample_sc;
  assign release_hit = prev_rel > sample_sc;

  // Blend as sample * one + f * (prev - sample), both factors in parallel
  assign diff    = (SW+1)'(prev) - (SW+1)'(s1_sample_q);
  assign acc_att = (ACC_W'(s1_sample_q) <<< arhe_pkg::FRAC_BITS)
                 + $signed({1'b0, cfg.attack_factor}) * ACC_W'(diff);
  assign acc_rel = (ACC_W'(s1_sample_q) <<< arhe_pkg::FRAC_BITS)
                 + $signed({1'b0, cfg.release_factor}) * ACC_W'(diff);
  assign acc_sel = attack_hit ? acc_att : acc_rel;

  // Round half up, then saturate to the sample range
  assign rounded = RND_W'((acc_sel + ACC_W'(1 << (arhe_pkg::FRAC_BITS - 1)))
                          >>> arhe_pkg::FRAC_BITS);

  always_comb begin
    if (rounded > RND_W'(arhe_pkg::SAMPLE_MAX)) begin
      blended = arhe_pkg::SAMPLE_MAX;
    end else if (rounded < RND_W'(arhe_pkg::SAMPLE_MIN)) begin
      blended = arhe_pkg::SAMPLE_MIN;
    end else begin
      blended = rounded[SW-1:0];
    end
  end

  // Attack wins over release; otherwise hold
  assign next_value = (attack_hit || release_hit) ? blended : prev;

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.channel_out  <= s1_chan_q;
      out_q.envelope_out <= s1_in_range_q ? next_value : '0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

[sim/tb_top.sv]
// Testbench for the attack/release hysteresis envelope smoother.
// Drives samples and APB register writes, predicts each channel's envelope.
// Depends on arhe_pkg, arhe_if and the attack_release_hysteresis_envelope top.
module tb_top;
  import arhe_pkg::*;

  localparam int unsigned NUM_CH         = CHANNELS_DEF;
  localparam int unsigned RAND_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS    = 128;
  localparam int unsigned SQUEEZE_CYCLES = 250;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  logic clk_i;
  logic rst_ni;

  // APB port
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  arhe_in_if  in_bus ();
  arhe_out_if out_bus ();

  // Stimulus and prediction state
  in_item_t                  stim_q[$];
  out_item_t                 envelope_q[$];
  logic signed [SAMPLE_W-1:0] level_mem[NUM_CH];
  logic signed [SAMPLE_W-1:0] walk[NUM_CH];
  cfg_t                      coef;

  logic        in_fire;
  logic        out_fire;
  logic        burst_mode;
  logic        squeeze_go;
  logic        rx_block;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned stall_cnt;
  int unsigned err_cnt;

  attack_release_hysteresis_envelope #(
    .CHANNELS(NUM_CH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Blend toward the sample with factor f on the previous value, round, saturate
  function automatic logic signed [SAMPLE_W-1:0] blend_q15(input longint s, input longint p,
                                                           input logic [COEF_W-1:0] f);
    longint fw;
    longint acc;
    fw  = longint'(f);
    acc = ((64'sd32768 - fw) * s + fw * p + 64'sd16384) >>> FRAC_BITS;
    if (acc > longint'(SAMPLE_MAX)) acc = longint'(SAMPLE_MAX);
    if (acc < longint'(SAMPLE_MIN)) acc = longint'(SAMPLE_MIN);
    return acc[SAMPLE_W-1:0];
  endfunction

  // Advance one channel's envelope and return the value the block must emit
  function automatic out_item_t next_envelope(input in_item_t it);
    out_item_t r;
    longint    s;
    longint    p;
    longint    sx;
    r.channel_out  = it.channel_index;
    r.envelope_out = '0;
    if (it.channel_index < NUM_CH) begin
      s  = longint'($signed(it.sample_in));
      p  = longint'($signed(level_mem[it.channel_index]));
      sx = s * 64'sd32768;
      if (p * longint'(coef.attack_threshold_ratio) < sx)
        level_mem[it.channel_index] = blend_q15(s, p, coef.attack_factor);
      else if (p * longint'(coef.release_threshold_ratio) > sx)
        level_mem[it.channel_index] = blend_q15(s, p, coef.release_factor);
      r.envelope_out = level_mem[it.channel_index];
    end
    return r;
  endfunction

  // Draw the idle cycles ahead of one transaction
  function automatic int unsigned draw_wait();
    if (burst_mode) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 4);
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_factor();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return ONE_Q15;
      2:       return 16'hFFFF;
      3:       return COEF_W'($urandom_range(28000, 32767));
      4:       return COEF_W'($urandom_range(0, 65535));
      default: return COEF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_ratio();
    case ($urandom_range(0, 5))
      0:       return ONE_Q15;
      1:       return COEF_W'($urandom_range(16384, 32768));
      2:       return '0;
      3:       return 16'hFFFF;
      default: return COEF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Mostly a random walk per channel, with extremes and wild values mixed in
  function automatic logic signed [SAMPLE_W-1:0] make_sample(input int unsigned ch);
    int unsigned pick;
    logic [31:0] raw;
    longint      w;
    longint      step;
    pick = $urandom_range(0, 9);
    raw  = $urandom;
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_MAX;
        1:       return SAMPLE_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 3) return raw[SAMPLE_W-1:0];
    step = longint'($urandom_range(0, 1 << $urandom_range(0, 21)));
    w    = raw[0] ? longint'($signed(walk[ch])) + step : longint'($signed(walk[ch])) - step;
    if (w > longint'(SAMPLE_MAX)) w = longint'(SAMPLE_MAX);
    if (w < longint'(SAMPLE_MIN)) w = longint'(SAMPLE_MIN);
    walk[ch] = w[SAMPLE_W-1:0];
    return walk[ch];
  endfunction

  task automatic push_item(input int unsigned ch, input logic signed [SAMPLE_W-1:0] s);
    in_item_t it;
    it.channel_index = CHAN_W'(ch);
    it.sample_in     = s;
    stim_q.push_back(it);
  endtask

  // One APB write: setup cycle, then access cycle until pready
  task automatic apb_write(input reg_idx_e idx, input logic [COEF_W-1:0] v);
    logic [31:0] junk;
    junk = $urandom;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[PDATA_W-COEF_W-1:0], v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ATTACK_FACTOR:  coef.attack_factor           = v;
      REG_RELEASE_FACTOR: coef.release_factor          = v;
      REG_ATTACK_RATIO:   coef.attack_threshold_ratio  = v;
      REG_RELEASE_RATIO:  coef.release_threshold_ratio = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] af, input logic [COEF_W-1:0] rf,
                           input logic [COEF_W-1:0] ar, input logic [COEF_W-1:0] rr);
    apb_write(REG_ATTACK_FACTOR, af);
    apb_write(REG_RELEASE_FACTOR, rf);
    apb_write(REG_ATTACK_RATIO, ar);
    apb_write(REG_RELEASE_RATIO, rr);
  endtask

  // Hold until every queued sample went in and every envelope came out
  task automatic wait_drained();
    do @(posedge clk_i); while (stim_q.size() != 0 || in_bus.valid || envelope_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Sample driver: offer queued items after their drawn gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      tx_wait      <= 0;
    end else if (!in_bus.valid || in_fire) begin
      if (tx_wait != 0) begin
        in_bus.valid <= 1'b0;
        tx_wait      <= tx_wait - 1;
      end else if (stim_q.size() != 0) begin
        in_bus.valid <= 1'b1;
        in_bus.data  <= stim_q.pop_front();
        tx_wait      <= draw_wait();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall after each transaction, or hold off entirely on request
  always @(negedge clk_i) begin : rx_drive
    int unsigned w;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_wait       <= 0;
    end else if (rx_block) begin
      out_bus.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_bus.ready <= 1'b0;
      rx_wait       <= rx_wait - 1;
    end else if (out_fire) begin
      w = draw_wait();
      if (w == 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b0;
        rx_wait       <= w - 1;
      end
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    rx_block = 1'b0;
    wait (squeeze_go);
    repeat (20) @(negedge clk_i);
    rx_block <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(negedge clk_i);
    rx_block <= 1'b0;
  end

  // Monitor: check results, predict accepted samples, watch for stalls
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    logic      any_fire;
    in_fire  <= rst_ni && in_bus.valid && in_bus.ready;
    out_fire <= rst_ni && out_bus.valid && out_bus.ready;
    any_fire = 1'b0;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      any_fire = 1'b1;
      if (envelope_q.size() == 0) begin
        $error("unexpected result transaction: channel_out %0d envelope_out %0d",
               out_bus.data.channel_out, $signed(out_bus.data.envelope_out));
        err_cnt++;
      end else begin
        want = envelope_q.pop_front();
        if (out_bus.data.channel_out !== want.channel_out) begin
          $error("channel_out mismatch: expected %0d, actual %0d",
                 want.channel_out, out_bus.data.channel_out);
          err_cnt++;
        end
        if (out_bus.data.envelope_out !== want.envelope_out) begin
          $error("envelope_out mismatch: expected %0d, actual %0d",
                 $signed(want.envelope_out), $signed(out_bus.data.envelope_out));
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      any_fire = 1'b1;
      envelope_q.push_back(next_envelope(in_bus.data));
    end
    if (psel && penable && pwrite && pready) any_fire = 1'b1;
    // Drop the run when nothing moves for too long
    if (!rst_ni || any_fire) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed checks, then random phases
  initial begin : main_seq
    int unsigned ph;
    int unsigned n;
    int unsigned ch;
    int unsigned focus;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    in_fire       = 1'b0;
    out_fire      = 1'b0;
    burst_mode    = 1'b0;
    squeeze_go    = 1'b0;
    tx_wait       = 0;
    rx_wait       = 0;
    stall_cnt     = 0;
    err_cnt       = 0;
    coef.attack_factor           = '0;
    coef.release_factor          = '0;
    coef.attack_threshold_ratio  = ONE_Q15;
    coef.release_threshold_ratio = ONE_Q15;
    for (int i = 0; i < NUM_CH; i++) begin
      level_mem[i] = '0;
      walk[i]      = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset coefficients: zero factors jump straight to the sample
    push_item(0, SAMPLE_MAX);
    push_item(0, SAMPLE_MAX);
    push_item(0, SAMPLE_MIN);
    push_item(0, '0);
    push_item(1, -24'sd1);
    push_item(1, 24'sd1);
    push_item(7, SAMPLE_MIN);
    push_item(7, SAMPLE_MAX);
    push_item(3, '0);
    wait_drained();

    // Hysteresis band: attack, hold inside the band, release below it
    set_coefs(16'd16384, 16'd32000, ONE_Q15, 16'd16384);
    push_item(2, 24'sd4000000);
    push_item(2, 24'sd1500000);
    push_item(2, 24'sd500000);
    push_item(2, SAMPLE_MIN);
    push_item(5, SAMPLE_MAX);
    push_item(5, SAMPLE_MAX);
    wait_drained();

    // Factors above one and a zero attack ratio drive the blend into saturation
    set_coefs(16'hFFFF, 16'hFFFF, '0, 16'hFFFF);
    push_item(4, SAMPLE_MAX);
    push_item(4, SAMPLE_MAX);
    push_item(4, SAMPLE_MIN);
    push_item(6, -24'sd5);
    push_item(6, SAMPLE_MIN);
    push_item(6, SAMPLE_MAX);
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       set_coefs('0, '0, '0, '0);
        1:       set_coefs(ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15);
        2:       set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3:       set_coefs(16'd32000, 16'd32700, ONE_Q15, 16'd26000);
        default: set_coefs(pick_factor(), pick_factor(), pick_ratio(), pick_ratio());
      endcase
      burst_mode = (ph == 3) || (ph == 7);
      if (ph == 3) squeeze_go = 1'b1;
      focus = $urandom_range(0, NUM_CH - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        ch = $urandom_range(0, 1) ? focus : $urandom_range(0, NUM_CH - 1);
        push_item(ch, make_sample(ch));
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (envelope_q.size() != 0) begin
      $error("%0d envelope results never arrived", envelope_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
